// File: hw/rtl/bmft_pkg.sv
// Shared types, constants and controller/datapath interface structs for the flash translation block.
package bmft_pkg;

	localparam int PAGES_PER_BLK_DEF = 32;
	localparam int DATA_BLOCKS_DEF   = 255;

	localparam int LSN_W  = 13;
	localparam int PAGE_W = 13;
	localparam int EBLK_W = 8;
	localparam int CMD_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PROGRAM  = 3'd0,
		CMD_READ     = 3'd1,
		CMD_COPY     = 3'd2,
		CMD_ERASE    = 3'd3,
		CMD_UNMAPPED = 3'd4
	} cmd_code_t;

	typedef struct packed {
		logic             kind;
		logic [LSN_W-1:0] logical_sector;
	} req_t;

	typedef struct packed {
		cmd_code_t         command;
		logic [PAGE_W-1:0] page_addr;
		logic [PAGE_W-1:0] source_page;
		logic [EBLK_W-1:0] erase_block;
		logic [LSN_W-1:0]  spare_sector;
		logic              last;
	} flash_cmd_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      clear;
		logic      load;
		logic      div1;
		logic      div2;
		logic      map_rd;
		logic      pick;
		logic      row_rd;
		logic      copy_init;
		logic      copy_adv;
		logic      emit;
		cmd_code_t code;
		logic      row_set;
		logic      relocate;
		logic      retire;
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_done;
		logic in_range;
		logic is_write;
		logic mapped;
		logic hit;
		logic skip;
		logic idx_last;
		logic out_free;
	} stat_t;

endpackage

// File: hw/rtl/bmft_ctrl.sv
// Request sequencer: walks each request through lookup and, for writes, the check and relocation steps.
module bmft_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bmft_pkg::stat_t st,
	output bmft_pkg::ctl_t  ctl
);
	import bmft_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b000_0000_0001,
		ST_IDLE   = 11'b000_0000_0010,
		ST_DIV1   = 11'b000_0000_0100,
		ST_DIV2   = 11'b000_0000_1000,
		ST_MAP    = 11'b000_0001_0000,
		ST_DECIDE = 11'b000_0010_0000,
		ST_ROW    = 11'b000_0100_0000,
		ST_CHECK  = 11'b000_1000_0000,
		ST_COPY   = 11'b001_0000_0000,
		ST_PROG   = 11'b010_0000_0000,
		ST_ERASE  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Next state and datapath commands
	always_comb begin
		ctl       = '0;
		ctl.code  = CMD_PROGRAM;
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clear = 1'b1;
				if (st.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_DIV1;
				end
			end
			ST_DIV1: begin
				ctl.div1 = 1'b1;
				state_d  = ST_DIV2;
			end
			ST_DIV2: begin
				ctl.div2 = 1'b1;
				state_d  = ST_MAP;
			end
			ST_MAP: begin
				ctl.map_rd = 1'b1;
				state_d    = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (st.is_write && st.in_range) begin
					ctl.pick = 1'b1;
					state_d  = ST_ROW;
				end else if (st.is_write) begin
					// drop writes beyond the mapped range
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					ctl.emit = 1'b1;
					ctl.code = (st.in_range && st.mapped) ? CMD_READ : CMD_UNMAPPED;
					state_d  = ST_IDLE;
				end else begin
					// hold until the command register frees
				end
			end
			ST_ROW: begin
				ctl.row_rd    = 1'b1;
				ctl.copy_init = 1'b1;
				state_d       = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (st.hit) begin
					state_d = ST_COPY;
				end else if (st.out_free) begin
					ctl.emit    = 1'b1;
					ctl.code    = CMD_PROGRAM;
					ctl.row_set = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					// hold until the command register frees
				end
			end
			ST_COPY: begin
				// one page per cycle while the command register is free; the page being overwritten is passed over
				priority if (st.skip) begin
					ctl.copy_adv = 1'b1;
					if (st.idx_last) begin
						state_d = ST_PROG;
					end
				end else if (st.out_free) begin
					ctl.emit     = 1'b1;
					ctl.code     = CMD_COPY;
					ctl.copy_adv = 1'b1;
					if (st.idx_last) begin
						state_d = ST_PROG;
					end
				end else begin
					// hold until the command register frees
				end
			end
			ST_PROG: begin
				if (st.out_free) begin
					ctl.emit     = 1'b1;
					ctl.code     = CMD_PROGRAM;
					ctl.relocate = 1'b1;
					state_d      = ST_ERASE;
				end
			end
			ST_ERASE: begin
				if (st.out_free) begin
					ctl.emit   = 1'b1;
					ctl.code   = CMD_ERASE;
					ctl.retire = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/bmft_dp.sv
// Datapath: sector split, block map and written-page stores, spare tracking and command register.
module bmft_dp #(
	parameter int PAGES_PER_BLK = bmft_pkg::PAGES_PER_BLK_DEF,
	parameter int DATA_BLOCKS   = bmft_pkg::DATA_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmft_pkg::req_t       req,
	input  bmft_pkg::ctl_t       ctl,
	output bmft_pkg::stat_t      st,
	output logic                 cmd_valid,
	input  logic                 cmd_stall,
	output bmft_pkg::flash_cmd_t cmd
);
	import bmft_pkg::*;

	localparam int PHYS_BLOCKS = DATA_BLOCKS + 1;
	localparam int BLK_W       = $clog2(PHYS_BLOCKS);
	localparam int MAPA_W      = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
	localparam int OFF_W       = $clog2(PAGES_PER_BLK);
	localparam int PPN_W       = BLK_W + OFF_W;
	localparam int PW_EXT      = (PPN_W > PAGE_W) ? PPN_W : PAGE_W;
	localparam int BW_EXT      = (BLK_W > EBLK_W) ? BLK_W : EBLK_W;
	localparam int PROD_W      = 2 * LSN_W;
	localparam int RECIP       = (1 << LSN_W) / PAGES_PER_BLK;

	// Stores
	logic [BLK_W:0]         map_mem [DATA_BLOCKS];
	logic [PAGES_PER_BLK-1:0] row_mem [PHYS_BLOCKS];

	// Request and lookup registers
	logic                     kind_q;
	logic [LSN_W-1:0]         lsn_q;
	logic [LSN_W-1:0]         q_est_q;
	logic [LSN_W-1:0]         lbn_q;
	logic [OFF_W-1:0]         off_q;
	logic [BLK_W:0]           map_rd_q;
	logic [BLK_W-1:0]         pbn_q;
	logic                     fresh_q;
	logic [PAGES_PER_BLK-1:0] row_q;
	logic [PPN_W-1:0]         base_src_q;
	logic [PPN_W-1:0]         base_spare_q;
	logic [OFF_W-1:0]         idx_q;
	logic [BLK_W-1:0]         spare_q;
	logic [BLK_W-1:0]         clr_q;
	logic                     out_valid_q;
	flash_cmd_t               out_q;

	logic [PROD_W-1:0]        recip_prod;
	logic [LSN_W-1:0]         q_mul;
	logic [LSN_W-1:0]         rem_raw;
	logic [LSN_W-1:0]         rem_adj;
	logic                     rem_over;
	logic                     in_range;
	logic [MAPA_W-1:0]        map_idx;
	logic [PAGES_PER_BLK-1:0] off_bit;
	logic [PAGES_PER_BLK-1:0] row_marked;
	logic [PPN_W-1:0]         read_ppn;
	logic                     out_free;

	logic                     map_we;
	logic [MAPA_W-1:0]        map_wa;
	logic [BLK_W:0]           map_wd;
	logic                     row_we;
	logic [BLK_W-1:0]         row_wa;
	logic [PAGES_PER_BLK-1:0] row_wd;
	flash_cmd_t               nxt;

	function automatic logic [PAGE_W-1:0] fit_page(input logic [PPN_W-1:0] v);
		logic [PW_EXT-1:0] w;
		w = PW_EXT'(v);
		return w[PAGE_W-1:0];
	endfunction

	function automatic logic [EBLK_W-1:0] fit_blk(input logic [BLK_W-1:0] v);
		logic [BW_EXT-1:0] w;
		w = BW_EXT'(v);
		return w[EBLK_W-1:0];
	endfunction

	// Sector split: reciprocal estimate, then one correction step
	assign recip_prod = PROD_W'(lsn_q) * PROD_W'(RECIP);
	assign q_mul      = q_est_q * LSN_W'(PAGES_PER_BLK);
	assign rem_raw    = lsn_q - q_mul;
	assign rem_over   = rem_raw >= LSN_W'(PAGES_PER_BLK);
	assign rem_adj    = rem_over ? rem_raw - LSN_W'(PAGES_PER_BLK) : rem_raw;

	assign in_range   = lbn_q < LSN_W'(DATA_BLOCKS);
	assign map_idx    = lbn_q[MAPA_W-1:0];
	assign off_bit    = {{(PAGES_PER_BLK-1){1'b0}}, 1'b1} << off_q;
	assign row_marked = row_q | off_bit;
	assign read_ppn   = PPN_W'(map_rd_q[BLK_W-1:0]) * PPN_W'(PAGES_PER_BLK) + PPN_W'(off_q);
	assign out_free   = !out_valid_q || !cmd_stall;

	// Status back to the controller
	always_comb begin
		st            = '0;
		st.clear_done = clr_q == BLK_W'(DATA_BLOCKS);
		st.in_range   = in_range;
		st.is_write   = kind_q;
		st.mapped     = map_rd_q[BLK_W];
		st.hit        = row_q[off_q] && !fresh_q;
		st.skip       = idx_q == off_q;
		st.idx_last   = idx_q == OFF_W'(PAGES_PER_BLK - 1);
		st.out_free   = out_free;
	end

	// Request capture and sector split
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q <= req.kind;
			lsn_q  <= req.logical_sector;
		end
		if (ctl.div1) begin
			q_est_q <= recip_prod[PROD_W-1:LSN_W];
		end
		if (ctl.div2) begin
			lbn_q <= rem_over ? q_est_q + LSN_W'(1) : q_est_q;
			off_q <= rem_adj[OFF_W-1:0];
		end
		if (ctl.pick) begin
			pbn_q   <= map_rd_q[BLK_W] ? map_rd_q[BLK_W-1:0] : lbn_q[BLK_W-1:0];
			fresh_q <= !map_rd_q[BLK_W];
		end
		if (ctl.row_rd) begin
			base_src_q   <= PPN_W'(pbn_q) * PPN_W'(PAGES_PER_BLK);
			base_spare_q <= PPN_W'(spare_q) * PPN_W'(PAGES_PER_BLK);
		end
	end

	// Block map write port select
	always_comb begin
		map_we = 1'b0;
		map_wa = map_idx;
		map_wd = '0;
		priority if (ctl.clear) begin
			map_we = clr_q < BLK_W'(DATA_BLOCKS);
			map_wa = clr_q[MAPA_W-1:0];
		end else if (ctl.pick) begin
			map_we = !map_rd_q[BLK_W];
			map_wd = {1'b1, lbn_q[BLK_W-1:0]};
		end else if (ctl.relocate) begin
			map_we = 1'b1;
			map_wd = {1'b1, spare_q};
		end else begin
			map_we = 1'b0;
		end
	end

	// Block map
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (ctl.map_rd && in_range) begin
			map_rd_q <= map_mem[map_idx];
		end
	end

	// Written-page row write port select
	always_comb begin
		row_we = 1'b1;
		row_wa = pbn_q;
		row_wd = '0;
		priority if (ctl.clear) begin
			row_wa = clr_q;
		end else if (ctl.row_set) begin
			row_wd = row_marked;
		end else if (ctl.relocate) begin
			row_wa = spare_q;
			row_wd = row_marked;
		end else if (ctl.retire) begin
			row_wd = '0;
		end else begin
			row_we = 1'b0;
		end
	end

	// Written-page flags, one row per physical block
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wa] <= row_wd;
		end
		if (ctl.row_rd) begin
			row_q <= row_mem[pbn_q];
		end
	end

	// Clear pass counter, copy index and spare block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			idx_q   <= '0;
			spare_q <= BLK_W'(DATA_BLOCKS);
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + BLK_W'(1);
			end
			if (ctl.copy_init) begin
				idx_q <= '0;
			end else if (ctl.copy_adv) begin
				idx_q <= (idx_q == OFF_W'(PAGES_PER_BLK - 1)) ? '0 : idx_q + OFF_W'(1);
			end
			if (ctl.retire) begin
				spare_q <= pbn_q;
			end
		end
	end

	// Build the next command item
	always_comb begin
		nxt         = '0;
		nxt.command = ctl.code;
		unique case (ctl.code)
			CMD_PROGRAM: begin
				nxt.spare_sector = lsn_q;
				if (ctl.relocate) begin
					nxt.page_addr = fit_page(base_spare_q + PPN_W'(off_q));
					nxt.last      = 1'b0;
				end else begin
					nxt.page_addr = fit_page(base_src_q + PPN_W'(off_q));
					nxt.last      = 1'b1;
				end
			end
			CMD_READ: begin
				nxt.page_addr = fit_page(read_ppn);
				nxt.last      = 1'b1;
			end
			CMD_COPY: begin
				nxt.page_addr   = fit_page(base_spare_q + PPN_W'(idx_q));
				nxt.source_page = fit_page(base_src_q + PPN_W'(idx_q));
			end
			CMD_ERASE: begin
				nxt.erase_block = fit_blk(pbn_q);
				nxt.last        = 1'b1;
			end
			CMD_UNMAPPED: begin
				nxt.last = 1'b1;
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!cmd_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q <= nxt;
		end
	end

	assign cmd_valid = out_valid_q;
	assign cmd       = out_q;

endmodule

// File: hw/rtl/block_mapped_flash_translation.sv
// Top level of the block-mapped flash translation unit.
// Each host request (read or write of one logical sector) turns into a short burst of flash
// command items; a write beyond the mapped range is dropped without any item. After reset the
// unit first clears its block map and written-page flags, one physical block per cycle, with
// req_stall high. Requests are then handled one at a time: an overwrite copies the other pages
// of the block into the spare block, one copy item per cycle through the single command
// register while it is free, before the program and erase items. A pending item held by
// cmd_stall holds up the sequencer. A finished item waits in the command register while the
// next request is taken.
module block_mapped_flash_translation #(
	parameter int PAGES_PER_BLK = bmft_pkg::PAGES_PER_BLK_DEF,
	parameter int DATA_BLOCKS   = bmft_pkg::DATA_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bmft_pkg::req_t       req,
	output logic                 cmd_valid,
	input  logic                 cmd_stall,
	output bmft_pkg::flash_cmd_t cmd
);
	import bmft_pkg::*;

	ctl_t  ctl;
	stat_t st;

	// Sequencer
	bmft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.ctl       (ctl)
	);

	// Stores and command formation
	bmft_dp #(
		.PAGES_PER_BLK (PAGES_PER_BLK),
		.DATA_BLOCKS   (DATA_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.st        (st),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd)
	);

endmodule

// File: hw/rtl/bmft_checker.sv
// Port-level checks on the command stream, bound to the top level.
module bmft_port_checks (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_stall,
	input bmft_pkg::flash_cmd_t cmd
);
	import bmft_pkg::*;

	// A stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("command item changed while stalled");

	// Read, unmapped read and erase always close a request
	a_closing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (cmd.command == CMD_READ || cmd.command == CMD_UNMAPPED ||
			cmd.command == CMD_ERASE) |-> cmd.last)
		else $error("read or erase item without last");

	// A copy never closes a request and carries no erase or tag
	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.command == CMD_COPY |->
			!cmd.last && cmd.erase_block == '0 && cmd.spare_sector == '0)
		else $error("malformed copy item");

	// An unmapped read carries no addresses
	a_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.command == CMD_UNMAPPED |->
			cmd.page_addr == '0 && cmd.source_page == '0 &&
			cmd.erase_block == '0 && cmd.spare_sector == '0)
		else $error("unmapped read item carries an address");

endmodule

bind block_mapped_flash_translation bmft_port_checks u_bmft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd)
);
